FILE: rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, widths and the predictor coefficient table of the 4-bit
// ADPCM frame decoder.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int FRAME_SAMPLES = 16;
	localparam int CNT_W         = $clog2(FRAME_SAMPLES);
	localparam int NIB_W         = 4;
	localparam int WORD_W        = 32;
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 14;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W         = 32;
	localparam int COEF_SHIFT    = 11;
	localparam int SHIFT_W       = ACC_W - COEF_SHIFT;
	localparam int SAT_MAX       = 32767;
	localparam int SAT_MIN       = -32768;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture a new frame
		logic step;  // decode one sample into the output register
		logic last;  // the sample being decoded ends the frame
	} afc_cmd_t;

	// Q11 weight of the most recent sample
	function automatic coef_t coef_new(input logic [3:0] sel);
		coef_t c;
		c = '0;
		case (sel)
			4'd0:  c = 14'sd0;
			4'd1:  c = 14'sh0800;
			4'd2:  c = 14'sd0;
			4'd3:  c = 14'sh0400;
			4'd4:  c = 14'sh1000;
			4'd5:  c = 14'sh0e00;
			4'd6:  c = 14'sh0c00;
			4'd7:  c = 14'sh1200;
			4'd8:  c = 14'sh1068;
			4'd9:  c = 14'sh12c0;
			4'd10: c = 14'sh1400;
			4'd11: c = 14'sh0800;
			4'd12: c = 14'sh0400;
			4'd13: c = -14'sh0400;
			4'd14: c = -14'sh0400;
			4'd15: c = -14'sh0800;
			default: c = 14'sd0;
		endcase
		return c;
	endfunction

	// Q11 weight of the sample before that
	function automatic coef_t coef_old(input logic [3:0] sel);
		coef_t c;
		c = '0;
		case (sel)
			4'd0:  c = 14'sd0;
			4'd1:  c = 14'sd0;
			4'd2:  c = 14'sh0800;
			4'd3:  c = 14'sh0400;
			4'd4:  c = -14'sh0800;
			4'd5:  c = -14'sh0600;
			4'd6:  c = -14'sh0400;
			4'd7:  c = -14'sh0a00;
			4'd8:  c = -14'sh08c8;
			4'd9:  c = -14'sh08fc;
			4'd10: c = -14'sh0c00;
			4'd11: c = -14'sh0800;
			4'd12: c = -14'sh0400;
			4'd13: c = 14'sh0400;
			4'd14: c = 14'sd0;
			4'd15: c = 14'sd0;
			default: c = 14'sd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/afc_ctrl.sv
// ----------------------------------------------------------------------------
// afc_ctrl
// Frame sequencer: takes a frame, issues sixteen decode steps, and owns the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module afc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output afc_pkg::afc_cmd_t cmd
);
	import afc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             step;
	logic             load;
	logic             cnt_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load      = in_valid && in_ready;
	assign cnt_end   = (cnt_q == CNT_W'(FRAME_SAMPLES - 1));

	// Advance only when the output register is free or being drained
	assign step = (state_q == ST_RUN) && (!out_valid_q || out_ready);

	assign cmd.load = load;
	assign cmd.step = step;
	assign cmd.last = cnt_end;

	// Sequence the sixteen samples of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (step) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold a result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/afc_dpath.sv
// ----------------------------------------------------------------------------
// afc_dpath
// Sample datapath: code shift register, two-tap predictor, floor shift,
// saturation, two-sample history and the output register payload.
// ----------------------------------------------------------------------------
module afc_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  afc_pkg::afc_cmd_t        cmd,
	input  logic [3:0]               scale_exp,
	input  logic [3:0]               coef_select,
	input  logic [31:0]              nibbles_hi,
	input  logic [31:0]              nibbles_lo,
	output logic signed [15:0]       sample,
	output logic                     last
);
	import afc_pkg::*;

	logic [2*WORD_W-1:0]       codes_q;
	logic [3:0]                scale_q;
	coef_t                     c_new_q;
	coef_t                     c_old_q;
	sample_t                   prev_q;
	sample_t                   prev_prev_q;
	sample_t                   sample_q;
	logic                      last_q;

	logic signed [ACC_W-1:0]   code_ext;
	logic signed [ACC_W-1:0]   step_term;
	logic signed [PROD_W-1:0]  prod_new;
	logic signed [PROD_W-1:0]  prod_old;
	logic signed [ACC_W-1:0]   acc;
	logic signed [SHIFT_W-1:0] acc_sh;
	sample_t                   sat;

	// Scale the current code: code * 2^scale * 2^11
	assign code_ext  = ACC_W'(signed'(codes_q[2*WORD_W-1 -: NIB_W]));
	assign step_term = code_ext <<< (5'(scale_q) + 5'(COEF_SHIFT));

	// Two-tap prediction from the history
	assign prod_new = prev_q * c_new_q;
	assign prod_old = prev_prev_q * c_old_q;
	assign acc      = step_term + ACC_W'(prod_new) + ACC_W'(prod_old);

	// Floor shift back to sample scale, then clamp
	assign acc_sh = SHIFT_W'(acc >>> COEF_SHIFT);

	always_comb begin
		if (acc_sh > SHIFT_W'(SAT_MAX)) begin
			sat = sample_t'(SAT_MAX);
		end else if (acc_sh < SHIFT_W'(SAT_MIN)) begin
			sat = sample_t'(SAT_MIN);
		end else begin
			sat = SAMPLE_W'(acc_sh);
		end
	end

	// Capture a frame, then drop one code per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			codes_q <= {nibbles_hi, nibbles_lo};
			scale_q <= scale_exp;
			c_new_q <= coef_new(coef_select);
			c_old_q <= coef_old(coef_select);
		end else if (cmd.step) begin
			codes_q <= {codes_q[2*WORD_W-NIB_W-1:0], NIB_W'(0)};
		end
	end

	// Push each decoded sample into the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev_prev_q <= '0;
		end else if (cmd.step) begin
			prev_q      <= sat;
			prev_prev_q <= prev_q;
		end
	end

	// Load the output register payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			sample_q <= sat;
			last_q   <= cmd.last;
		end
	end

	assign sample = sample_q;
	assign last   = last_q;

endmodule

FILE: rtl/afc_adpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// afc_adpcm_frame_decoder
// 4-bit ADPCM frame decoder: one 9-byte frame in, sixteen PCM samples out.
// ----------------------------------------------------------------------------
// Each accepted frame yields sixteen signed 16-bit samples in order, the
// sixteenth flagged by last. One sample is decoded per cycle through a single
// predictor loop (two multiplies, add, floor shift, clamp, history update).
// A frame is taken while the sequencer is idle, then decoded in sixteen
// steps, one per cycle while the output side takes every sample. A stalled
// output holds the loop. A new frame is accepted once the sixteenth sample has
// been decoded, while that sample still waits in the output register. The
// two-sample history resets to zero and carries across frames.
module afc_adpcm_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         scale_exp,
	input  logic [3:0]         coef_select,
	input  logic [31:0]        nibbles_hi,
	input  logic [31:0]        nibbles_lo,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               last
);
	import afc_pkg::*;

	afc_cmd_t cmd;

	// Sequencer
	afc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Predictor datapath
	afc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.scale_exp   (scale_exp),
		.coef_select (coef_select),
		.nibbles_hi  (nibbles_hi),
		.nibbles_lo  (nibbles_lo),
		.sample      (sample),
		.last        (last)
	);

endmodule
